### rtl/esp_anti_replay_window_assert.svh
// ----------------------------------------------------------------------------
// esp_anti_replay_window_assert.svh
// Assertion macros for the ESP anti-replay window; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ESP_ANTI_REPLAY_WINDOW_ASSERT_SVH
`define ESP_ANTI_REPLAY_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked only while out of reset.
`define ESP_ARW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define ESP_ARW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ESP_ARW_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESP_ARW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/esp_arw_pkg.sv
// ----------------------------------------------------------------------------
// esp_arw_pkg
// Shared types and constants of the ESP anti-replay window.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_arw_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned NextW = SeqW + 1;
  localparam int unsigned MapW  = 64;
  localparam int unsigned IdxW  = $clog2(MapW);

  // farthest distance behind next that the map still covers
  localparam logic [NextW-1:0] MaxDist = NextW'(MapW + 1);

  typedef enum logic [2:0] {
    VERDICT_EXPECTED = 3'd0,
    VERDICT_NEWER    = 3'd1,
    VERDICT_OOO      = 3'd2,
    VERDICT_TOO_OLD  = 3'd3,
    VERDICT_REPLAY   = 3'd4
  } verdict_t;

  // check result plus proposed next window state
  typedef struct packed {
    logic              accepted;
    verdict_t          verdict;
    logic              upd;
    logic [NextW-1:0]  next_nxt;
    logic [MapW-1:0]   map_nxt;
  } chk_res_t;

endpackage

`default_nettype wire

### rtl/esp_arw_check.sv
// ----------------------------------------------------------------------------
// esp_arw_check
// Classifies one sequence number against the window and computes new state.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_arw_check
  import esp_arw_pkg::*;
(
  input  wire logic [SeqW-1:0]  seq,
  input  wire logic [NextW-1:0] next_expected,
  input  wire logic [MapW-1:0]  missing_map,
  input  wire logic             replay_protect,
  output chk_res_t              res
);

  logic [NextW-1:0] seq_ext;
  logic [NextW-1:0] delta;
  logic [NextW-1:0] lag;
  logic             is_eq;
  logic             is_new;
  logic             far_ahead;
  logic [IdxW:0]    shamt;
  logic [MapW-1:0]  new_map;
  logic [IdxW-1:0]  idx;
  logic             hit;

  assign seq_ext   = {1'b0, seq};
  assign is_eq     = (seq_ext == next_expected);
  assign is_new    = (seq_ext > next_expected);
  assign delta     = seq_ext - next_expected;
  assign lag       = next_expected - seq_ext;
  assign far_ahead = |delta[NextW-1:IdxW];

  // shift by delta+1 (a shift by the full width empties the map), then mark
  // the delta skipped packets as missing
  assign shamt   = {1'b0, delta[IdxW-1:0]} + (IdxW+1)'(1);
  assign new_map = far_ahead ? '1
                 : ((missing_map << shamt) | ~({MapW{1'b1}} << delta[IdxW-1:0]));

  // bit k stands for next-2-k
  assign idx = lag[IdxW-1:0] - IdxW'(2);
  assign hit = missing_map[idx];

  always_comb begin
    res          = '0;
    res.next_nxt = seq_ext + NextW'(1);
    res.map_nxt  = missing_map;
    if (is_eq) begin
      res.verdict  = VERDICT_EXPECTED;
      res.accepted = 1'b1;
      res.upd      = 1'b1;
      res.map_nxt  = missing_map << 1;
    end else if (is_new) begin
      res.verdict  = VERDICT_NEWER;
      res.accepted = 1'b1;
      res.upd      = 1'b1;
      res.map_nxt  = new_map;
    end else if (lag > MaxDist) begin
      res.verdict  = VERDICT_TOO_OLD;
      res.accepted = ~replay_protect;
    end else if (lag == NextW'(1) || !hit) begin
      res.verdict  = VERDICT_REPLAY;
      res.accepted = ~replay_protect;
    end else begin
      res.verdict      = VERDICT_OOO;
      res.accepted     = 1'b1;
      res.upd          = 1'b1;
      res.next_nxt     = next_expected;
      res.map_nxt[idx] = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/esp_anti_replay_window.sv
// ----------------------------------------------------------------------------
// esp_anti_replay_window
// 64-deep ESP anti-replay window with valid/ready beats on both sides.
// ----------------------------------------------------------------------------
// One beat in carries a 32-bit ESP sequence number; one beat out carries
// its verdict (expected, newer, out-of-order in window, too old, replayed)
// and whether the packet is passed on. The block takes one beat per cycle
// back to back while out_ready stays high; each beat is held in the input
// register, checked against the window state and then loaded into the
// result register. The rate is set by the window state loop:
// next-expected counter and missing-packet map are read and rewritten by
// the check logic once per cycle. While a result waits, one more beat is
// taken into the input register; then in_ready drops until the output side
// drains, so at most two beats are in flight. cfg_wr_data is the
// replay_protect bit (reset 1); with it low, too-old and replayed packets
// are passed but still reported. Write it only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "esp_anti_replay_window_assert.svh"

module esp_anti_replay_window
  import esp_arw_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,

  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,

  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [SeqW-1:0] in_seq_number,

  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_accepted,
  output logic [2:0]           out_verdict
);

  // input stage
  logic             in_valid_r;
  logic [SeqW-1:0]  in_seq_r;

  // result stage
  logic             out_valid_r;
  logic             out_accepted_r;
  verdict_t         out_verdict_r;

  // window state
  logic [NextW-1:0] next_expected_r;
  logic [MapW-1:0]  missing_map_r;
  logic             replay_protect_r;

  logic             out_free;
  logic             adv;
  chk_res_t         chk;

  // result register empty or being drained this cycle
  assign out_free = ~out_valid_r | out_ready;
  // input beat moves through the check into the result register
  assign adv      = in_valid_r & out_free;
  assign in_ready = ~in_valid_r | adv;

  esp_arw_check u_check (
    .seq            (in_seq_r),
    .next_expected  (next_expected_r),
    .missing_map    (missing_map_r),
    .replay_protect (replay_protect_r),
    .res            (chk)
  );

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      next_expected_r  <= '0;
      missing_map_r    <= '0;
      replay_protect_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        replay_protect_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      // rejected packets leave the window alone
      if (adv && chk.upd) begin
        next_expected_r <= chk.next_nxt;
        missing_map_r   <= chk.map_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_seq_r <= in_seq_number;
    end
    if (adv) begin
      out_accepted_r <= chk.accepted;
      out_verdict_r  <= chk.verdict;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;
  assign out_verdict  = out_verdict_r;

  // a discarded packet is always too old or replayed
  `ESP_ARW_ASSERT(a_reject_class, clk, rst_n,
    (out_valid_r && !out_accepted_r) |->
      (out_verdict_r == VERDICT_TOO_OLD || out_verdict_r == VERDICT_REPLAY),
    "discarded packet with a passing verdict")

  // window state frozen on a rejected beat
  `ESP_ARW_ASSERT(a_reject_no_update, clk, rst_n,
    (adv && !chk.upd) |=>
      (next_expected_r == $past(next_expected_r) &&
       missing_map_r == $past(missing_map_r)),
    "window state changed on a rejected packet")

  // expected or newer packet moves next past it
  `ESP_ARW_ASSERT(a_next_advance, clk, rst_n,
    (adv && (chk.verdict == VERDICT_EXPECTED || chk.verdict == VERDICT_NEWER)) |=>
      (next_expected_r == $past({1'b0, in_seq_r}) + NextW'(1)),
    "next-expected not advanced past accepted packet")

  // while protection is on, too-old and replayed beats are never passed
  `ESP_ARW_ASSERT(a_protect_drops, clk, rst_n,
    (adv && replay_protect_r &&
     (chk.verdict == VERDICT_TOO_OLD || chk.verdict == VERDICT_REPLAY)) |->
      !chk.accepted,
    "replay passed with protection on")

  // reset leaves both stages empty
  `ESP_ARW_ASSERT_ALWAYS(a_no_phantom, clk,
    (!rst_n) |=> (!in_valid_r && !out_valid_r),
    "valid stage left set by reset")

endmodule

`default_nettype wire
